### hdl/apsc_pkg.sv
// ----------------------------------------------------------------------------
// apsc_pkg
// Shared constants and controller/datapath interface types of the
// auto-calibrating pedal scaler.
// ----------------------------------------------------------------------------
package apsc_pkg;

    localparam int SAMPLE_BITS_DEF = 10;

    // Width and reset value of the cutoff divisor register.
    localparam int          CFG_BITS     = 7;
    localparam logic [6:0]  CUTOFF_RESET = 7'd8;

    // Scaled position: 8 bits, full scale is 256 per span.
    localparam int          POS_BITS    = 8;
    localparam int          SCALE_SHIFT = 8;
    localparam logic [7:0]  POS_MAX     = 8'd255;

    // Command codes carried in the input word's tuser bit.
    localparam logic CMD_SEED  = 1'b0;
    localparam logic CMD_TRACK = 1'b1;

    typedef struct packed {
        logic load_in;      // latch the input word and update the marks
        logic div_start;    // start the shared divider
        logic div_sel_map;  // 1: map the sample, 0: size the dead zone
        logic commit_map;   // store the new offset and span
        logic commit_out;   // store the result word in the output register
    } apsc_cmd_t;

    typedef struct packed {
        logic changed;      // a mark moved or the word was a seed
        logic cutoff_zero;  // cutoff divisor is zero, no dead zone
        logic div_done;     // divider result is ready
        logic out_busy;     // output register holds a word not yet taken
    } apsc_status_t;

endpackage

### hdl/auto_calibrating_pedal_scaler_top.sv
// ----------------------------------------------------------------------------
// auto_calibrating_pedal_scaler_top
// Auto-ranging pedal scaler: tracks the lowest and highest ADC reading and
// maps each reading to an 8-bit position with a dead zone at pedal-down.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on the s_ channel: the raw reading in s_tdata and the
//   command in s_tuser (0 seeds both marks, 1 tracks). Every input word gives
//   exactly one result word on the m_ channel: position in m_tdata and the
//   inverted flag in m_tuser. The cutoff divisor is written on the cfg_
//   channel, which is always ready; write it only while no word is in flight.
//   One word is processed at a time. A word whose marks stay put needs one
//   division, the mapping, and so does any word while the divisor is zero.
//   With a nonzero divisor a seed, or a word that moves a mark, needs two,
//   since the dead zone and the mapping both pass through the single
//   iterative divider, one quotient bit per cycle over SAMPLE_BITS+10 bits.
//   The result word shows up on m_tvalid in the same cycle that s_tready
//   rises again, and the next word can be accepted in that cycle.
//   A result waiting in the output register does not block the next word;
//   only the store of the following result waits while the receiver stalls.
//   Reset clears the marks and offset, sets the span to one and the divisor
//   to eight, and drops m_tvalid.
// ----------------------------------------------------------------------------
module auto_calibrating_pedal_scaler_top import apsc_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_tdata,  // sample
    input  logic [0:0]                            s_tuser,  // command
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [POS_BITS-1:0]                   m_tdata,  // position
    output logic [0:0]                            m_tuser,  // inverted
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [CFG_BITS-1:0]                   cfg_data
);

    apsc_cmd_t    cmd;
    apsc_status_t status;

    assign cfg_ready = 1'b1;

    apsc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    apsc_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_write  (cfg_valid & cfg_ready),
        .cfg_data   (cfg_data),
        .command_in (s_tuser[0]),
        .sample_in  (s_tdata[SAMPLE_BITS-1:0]),
        .m_tready   (m_tready),
        .cmd        (cmd),
        .status     (status),
        .m_tvalid   (m_tvalid),
        .position   (m_tdata),
        .inverted   (m_tuser[0])
    );

endmodule

### hdl/apsc_divider.sv
// ----------------------------------------------------------------------------
// apsc_divider
// Iterative signed divider, one restoring step per cycle. The quotient is
// returned as a magnitude and a sign, which truncates toward zero.
// ----------------------------------------------------------------------------
module apsc_divider import apsc_pkg::*; #(
    parameter int NW = SAMPLE_BITS_DEF + 10,
    parameter int DW = SAMPLE_BITS_DEF + 3
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [NW-1:0] dividend,
    input  logic signed [DW-1:0] divisor,
    output logic        [NW-1:0] quot,
    output logic                 neg,
    output logic                 done
);

    localparam int CW = $clog2(NW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] count_reg;
    logic [NW-1:0] q_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] dmag_reg;
    logic          neg_reg;

    logic [DW:0]   rem_shift;
    logic          fits;
    logic [DW:0]   rem_diff;
    logic [DW-1:0] rem_next;
    logic [NW-1:0] q_next;
    logic [NW-1:0] nmag;
    logic [DW-1:0] dmag;

    assign nmag = dividend[NW-1] ? NW'(-dividend) : NW'(dividend);
    assign dmag = divisor[DW-1]  ? DW'(-divisor)  : DW'(divisor);

    assign rem_shift = {rem_reg, q_reg[NW-1]};
    assign fits      = rem_shift >= {1'b0, dmag_reg};
    assign rem_diff  = rem_shift - {1'b0, dmag_reg};
    // The remainder always stays below the divisor, so the top bit drops.
    assign rem_next  = fits ? rem_diff[DW-1:0] : rem_shift[DW-1:0];
    assign q_next    = {q_reg[NW-2:0], fits};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                count_reg <= CW'(NW);
                q_reg     <= nmag;
                rem_reg   <= '0;
                dmag_reg  <= dmag;
                neg_reg   <= dividend[NW-1] ^ divisor[DW-1];
            end else if (busy_reg) begin
                q_reg     <= q_next;
                rem_reg   <= rem_next;
                count_reg <= count_reg - CW'(1);
                if (count_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quot = q_reg;
    assign neg  = neg_reg;
    assign done = done_reg;

endmodule

### hdl/apsc_datapath.sv
// ----------------------------------------------------------------------------
// apsc_datapath
// Marks, offset and span registers, operand selection for the shared
// divider, result clipping and the output register.
// ----------------------------------------------------------------------------
module apsc_datapath import apsc_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_write,
    input  logic [CFG_BITS-1:0]    cfg_data,
    input  logic                   command_in,
    input  logic [SAMPLE_BITS-1:0] sample_in,
    input  logic                   m_tready,
    input  apsc_cmd_t              cmd,
    output apsc_status_t           status,
    output logic                   m_tvalid,
    output logic [POS_BITS-1:0]    position,
    output logic                   inverted
);

    localparam int W    = SAMPLE_BITS + 3;   // working width of offset/span
    localparam int MAPW = SAMPLE_BITS + 2;   // stored offset/span width
    localparam int NW   = SAMPLE_BITS + 10;  // dividend width

    localparam logic signed [W-1:0] ONE_W   = W'(1);
    localparam logic signed [W-1:0] ZERO_W  = W'(0);
    localparam logic signed [W-1:0] WIDE_MAX = W'((1 << (SAMPLE_BITS + 1)) - 1);
    localparam logic signed [W-1:0] WIDE_MIN = -WIDE_MAX - ONE_W;

    logic [CFG_BITS-1:0]     cutoff_reg;
    logic [SAMPLE_BITS-1:0]  low_reg;
    logic [SAMPLE_BITS-1:0]  high_reg;
    logic [SAMPLE_BITS-1:0]  sample_reg;
    logic                    changed_reg;
    logic signed [MAPW-1:0]  offset_reg;
    logic signed [MAPW-1:0]  span_reg;
    logic                    valid_reg;
    logic [POS_BITS-1:0]     pos_reg;
    logic                    inv_reg;

    logic [SAMPLE_BITS:0]    mark_sum;
    logic                    dir_pos;
    logic signed [W-1:0]     lo_w;
    logic signed [W-1:0]     hi_w;
    logic signed [W-1:0]     off_raw;
    logic signed [W-1:0]     span_raw;
    logic signed [W-1:0]     q_w;
    logic signed [W-1:0]     widen;
    logic signed [W-1:0]     off_new;
    logic signed [W-1:0]     span_new;
    logic signed [W-1:0]     off_clip;
    logic signed [W-1:0]     span_clip;
    logic signed [MAPW-1:0]  offset_next;
    logic signed [MAPW-1:0]  span_next;

    logic signed [W-1:0]     diff;
    logic signed [NW-1:0]    num_map;
    logic signed [NW-1:0]    div_dividend;
    logic signed [W-1:0]     div_divisor;
    logic [NW-1:0]           div_quot;
    logic                    div_neg;
    logic                    div_done;
    logic [POS_BITS-1:0]     pos_next;

    // Direction and raw span from the current marks.
    assign mark_sum = {1'b0, low_reg} + {1'b0, high_reg};
    assign dir_pos  = ~mark_sum[SAMPLE_BITS];
    assign lo_w     = $signed(W'(low_reg));
    assign hi_w     = $signed(W'(high_reg));
    assign off_raw  = dir_pos ? lo_w : hi_w;
    assign span_raw = dir_pos ? (hi_w - lo_w + ONE_W) : (lo_w - hi_w - ONE_W);

    // The dead zone never exceeds the span, so the quotient fits in W bits.
    assign q_w      = $signed(div_quot[W-1:0]);
    assign widen    = status.cutoff_zero ? ZERO_W : (div_neg ? -q_w : q_w);
    assign off_new  = (span_raw > ZERO_W) ? (off_raw - widen) : (off_raw + widen);
    assign span_new = span_raw + widen;

    always_comb begin
        if (off_new > WIDE_MAX) begin
            off_clip = WIDE_MAX;
        end else if (off_new < WIDE_MIN) begin
            off_clip = WIDE_MIN;
        end else begin
            off_clip = off_new;
        end
        if (span_new > WIDE_MAX) begin
            span_clip = WIDE_MAX;
        end else if (span_new < WIDE_MIN) begin
            span_clip = WIDE_MIN;
        end else begin
            span_clip = span_new;
        end
        offset_next = off_clip[MAPW-1:0];
        span_next   = (span_clip == ZERO_W) ? MAPW'(1) : span_clip[MAPW-1:0];
    end

    // Mapping numerator: (sample - offset) * 256.
    assign diff    = $signed(W'(sample_reg)) - W'(offset_reg);
    assign num_map = NW'(diff) <<< SCALE_SHIFT;

    assign div_dividend = cmd.div_sel_map ? num_map : NW'(span_raw);
    assign div_divisor  = cmd.div_sel_map ? W'(span_reg) : $signed(W'(cutoff_reg));

    apsc_divider #(
        .NW (NW),
        .DW (W)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quot     (div_quot),
        .neg      (div_neg),
        .done     (div_done)
    );

    // A negative quotient clips to fully down, a large one to full scale.
    always_comb begin
        if (div_neg && (div_quot != '0)) begin
            pos_next = '0;
        end else if (div_quot > NW'(POS_MAX)) begin
            pos_next = POS_MAX;
        end else begin
            pos_next = div_quot[POS_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cutoff_reg  <= CUTOFF_RESET;
            low_reg     <= '0;
            high_reg    <= '0;
            offset_reg  <= '0;
            span_reg    <= MAPW'(1);
            changed_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end else begin
            if (cfg_write) begin
                cutoff_reg <= cfg_data;
            end
            if (cmd.load_in) begin
                sample_reg <= sample_in;
                if (command_in == CMD_SEED) begin
                    low_reg     <= sample_in;
                    high_reg    <= sample_in;
                    changed_reg <= 1'b1;
                end else begin
                    changed_reg <= (sample_in < low_reg) || (sample_in > high_reg);
                    if (sample_in < low_reg) begin
                        low_reg <= sample_in;
                    end
                    if (sample_in > high_reg) begin
                        high_reg <= sample_in;
                    end
                end
            end
            if (cmd.commit_map) begin
                offset_reg <= offset_next;
                span_reg   <= span_next;
            end
            if (cmd.commit_out) begin
                valid_reg <= 1'b1;
                pos_reg   <= pos_next;
                inv_reg   <= span_reg[MAPW-1];
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign status.changed     = changed_reg;
    assign status.cutoff_zero = (cutoff_reg == '0);
    assign status.div_done    = div_done;
    assign status.out_busy    = valid_reg & ~m_tready;

    assign m_tvalid = valid_reg;
    assign position = pos_reg;
    assign inverted = inv_reg;

endmodule

### hdl/apsc_ctrl.sv
// ----------------------------------------------------------------------------
// apsc_ctrl
// Sequencer of the pedal scaler: accepts a word, re-derives the map when a
// mark moved, runs the mapping division and hands the result to the output.
// ----------------------------------------------------------------------------
module apsc_ctrl import apsc_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  apsc_status_t status,
    output apsc_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DERIVE,
        ST_MAP_START,
        ST_MAP,
        ST_OUT
    } state_t;

    state_t state_reg;
    logic   ready_reg;

    always_comb begin
        cmd = '0;
        cmd.load_in = ready_reg & s_tvalid;
        case (state_reg)
            ST_CHECK: begin
                if (status.changed && !status.cutoff_zero) begin
                    cmd.div_start = 1'b1;
                end
                // Without a dead zone the map is stored right away.
                if (status.changed && status.cutoff_zero) begin
                    cmd.commit_map = 1'b1;
                end
            end
            ST_DERIVE: begin
                cmd.commit_map = status.div_done;
            end
            ST_MAP_START: begin
                cmd.div_start   = 1'b1;
                cmd.div_sel_map = 1'b1;
            end
            ST_MAP: begin
                cmd.div_sel_map = 1'b1;
            end
            ST_OUT: begin
                cmd.commit_out = ~status.out_busy;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid && ready_reg) begin
                        ready_reg <= 1'b0;
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (status.changed && !status.cutoff_zero) begin
                        state_reg <= ST_DERIVE;
                    end else begin
                        state_reg <= ST_MAP_START;
                    end
                end
                ST_DERIVE: begin
                    if (status.div_done) begin
                        state_reg <= ST_MAP_START;
                    end
                end
                ST_MAP_START: begin
                    state_reg <= ST_MAP;
                end
                ST_MAP: begin
                    if (status.div_done) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!status.out_busy) begin
                        ready_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    ready_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = ready_reg;

endmodule
